/* rtl/mrcc_pkg.sv */
package mrcc_pkg;

    // Frame limits and CRC-16/MODBUS constants.
    localparam logic [6:0]  MaxFrame = 7'd75;
    localparam logic [6:0]  MinFrame = 7'd3;
    localparam logic [15:0] CrcInit  = 16'hFFFF;
    localparam logic [15:0] CrcPoly  = 16'hA001;

    // Result queue geometry.
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_CRC_ERR  = 2'd2,
        ST_OVERLONG = 2'd3
    } t_status;

    typedef struct packed {
        t_kind       item_kind;
        logic [7:0]  payload_byte;
        t_status     frame_status;
        logic [6:0]  frame_length;
        logic        last_item;
    } t_result;

    // Up to two result words produced by one accepted byte.
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

/* rtl/mrcc_crc_byte.sv */
module mrcc_crc_byte (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    // Reflected CRC-16 update over one byte, one bit per step.
    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mrcc_pkg::CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

/* rtl/mrcc_frame.sv */
module mrcc_frame (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_frame_end,
    output mrcc_pkg::t_push o_push
);

    logic [6:0]  r_count, n_count;
    logic [7:0]  r_d0, n_d0;
    logic [7:0]  r_d1, n_d1;
    logic [15:0] r_crc, n_crc;
    logic        r_over, n_over;

    logic        keep;
    logic        emit;
    logic [15:0] crc_fed;
    mrcc_pkg::t_status status;

    // The CRC is fed with the oldest byte of the delay line as it leaves.
    mrcc_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (r_d1),
        .o_crc  (crc_fed)
    );

    // Next state for one byte; a full frame drops the byte.
    always_comb begin
        keep    = (r_count < mrcc_pkg::MaxFrame);
        emit    = keep && (r_count >= mrcc_pkg::MinFrame);
        n_crc   = emit ? crc_fed : r_crc;
        n_d0    = keep ? i_rx_byte : r_d0;
        n_d1    = keep ? r_d0 : r_d1;
        n_count = keep ? (r_count + 7'd1) : r_count;
        n_over  = r_over | ~keep;
    end

    // Frame status as seen after this byte.
    always_comb begin
        priority if (n_over) begin
            status = mrcc_pkg::ST_OVERLONG;
        end else if (n_count < mrcc_pkg::MinFrame) begin
            status = mrcc_pkg::ST_SHORT;
        end else if ({n_d0, n_d1} == n_crc) begin
            status = mrcc_pkg::ST_OK;
        end else begin
            status = mrcc_pkg::ST_CRC_ERR;
        end
    end

    // Result words: the payload word goes first, the status word second.
    always_comb begin
        mrcc_pkg::t_result pay;
        mrcc_pkg::t_result sts;
        pay.item_kind    = mrcc_pkg::KIND_PAYLOAD;
        pay.payload_byte = r_d1;
        pay.frame_status = mrcc_pkg::ST_OK;
        pay.frame_length = 7'd0;
        pay.last_item    = 1'b0;
        sts.item_kind    = mrcc_pkg::KIND_STATUS;
        sts.payload_byte = 8'd0;
        sts.frame_status = status;
        sts.frame_length = n_count;
        sts.last_item    = 1'b1;
        o_push.valid0 = i_accept && (emit || i_frame_end);
        o_push.valid1 = i_accept && emit && i_frame_end;
        o_push.res0   = emit ? pay : sts;
        o_push.res1   = sts;
    end

    // Frame state; the last byte of a frame returns everything to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_frame_end)) begin
            r_count <= 7'd0;
            r_d0    <= 8'd0;
            r_d1    <= 8'd0;
            r_crc   <= mrcc_pkg::CrcInit;
            r_over  <= 1'b0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_d0    <= n_d0;
            r_d1    <= n_d1;
            r_crc   <= n_crc;
            r_over  <= n_over;
        end
    end

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mrcc_pkg::MaxFrame)
        else $error("byte count above frame limit");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_frame_end) |=> (r_count == 7'd0 && !r_over))
        else $error("frame state not cleared after frame end");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid1 |-> (o_push.res0.item_kind == mrcc_pkg::KIND_PAYLOAD
                           && o_push.res1.last_item))
        else $error("two-word push not payload then status");

    a_over_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_frame_end && r_over) |->
            (o_push.res0.frame_status == mrcc_pkg::ST_OVERLONG))
        else $error("overlong frame without overlong status");

endmodule

/* rtl/mrcc_outq.sv */
module mrcc_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrcc_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_room,
    output mrcc_pkg::t_result o_head
);

    mrcc_pkg::t_result r_mem [mrcc_pkg::QDepth];

    logic [mrcc_pkg::QPtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [mrcc_pkg::QPtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [mrcc_pkg::QCntW-1:0] r_count, n_count;
    logic [1:0]                 n_pushes;

    // Head of the queue and the room check for a two-word push.
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= mrcc_pkg::QCntW'(mrcc_pkg::QDepth - 2));
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_pushes = {1'b0, i_push.valid0} + {1'b0, i_push.valid1};
        n_wr_ptr = r_wr_ptr + mrcc_pkg::QPtrW'(n_pushes);
        n_rd_ptr = r_rd_ptr + mrcc_pkg::QPtrW'(i_pop);
        n_count  = r_count + mrcc_pkg::QCntW'(n_pushes) - mrcc_pkg::QCntW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage; the second word lands in the slot after the first.
    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.valid1) begin
            r_mem[r_wr_ptr + mrcc_pkg::QPtrW'(1)] <= i_push.res1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mrcc_pkg::QCntW'(mrcc_pkg::QDepth))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid0 |-> o_room)
        else $error("push without room for two words");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty result queue");

endmodule

/* rtl/meter_response_crc_checker.sv */
// Channel  | Direction | Handshake                 | Word
// ---------+-----------+---------------------------+------------------------------------
// input    | in        | i_in_valid / o_in_stall   | i_rx_byte, i_frame_end
// output   | out       | o_out_valid / i_out_stall | o_item_kind, o_payload_byte,
//          |           |                           | o_frame_status, o_frame_length,
//          |           |                           | o_last_item
//
// A byte is accepted per cycle unless stalled; state and result words land at that edge.
// A byte yields zero, one or two words; the last byte of a frame may yield two.
// Words are registered into a four-entry result queue and leave it in order.
// o_in_stall is high while fewer than two queue slots are free.
// Reset (i_rst_n low, synchronous) clears the frame state and empties the queue.
module meter_response_crc_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_item_kind,
    output logic [7:0] o_payload_byte,
    output logic [1:0] o_frame_status,
    output logic [6:0] o_frame_length,
    output logic       o_last_item
);

    logic              accept;
    logic              pop;
    logic              room;
    mrcc_pkg::t_push   push;
    mrcc_pkg::t_result head;

    // Handshakes on both sides.
    assign o_in_stall = ~room;
    assign accept     = i_in_valid & room;
    assign pop        = o_out_valid & ~i_out_stall;

    mrcc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_frame_end (i_frame_end),
        .o_push      (push)
    );

    mrcc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (o_out_valid),
        .o_room  (room),
        .o_head  (head)
    );

    // Output word fields.
    assign o_item_kind    = head.item_kind;
    assign o_payload_byte = head.payload_byte;
    assign o_frame_status = head.frame_status;
    assign o_frame_length = head.frame_length;
    assign o_last_item    = head.last_item;

endmodule

/* dv/tb_meter_response_crc_checker.sv */
module tb_meter_response_crc_checker;

    // Frame rules and CRC-16/MODBUS constants.
    localparam int          FRAME_LIMIT  = 75;
    localparam int          FRAME_MIN    = 3;
    localparam logic [15:0] CRC_SEED     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REV = 16'hA001;

    // Run control.
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 60;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASE_ITEMS = 100;

    // How the CRC bytes at the tail of a frame are filled in.
    typedef enum int {
        CRC_GOOD,
        CRC_FLIPPED,
        CRC_AS_IS
    } t_crc_fill;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       frame_end;
    logic       out_valid;
    logic       out_stall;
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [1:0] frame_status;
    logic [6:0] frame_length;
    logic       last_item;

    // Idle rates in percent and the long receiver hold request.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          hold_requests = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;

    int          quiet_cycles  = 0;
    int          errors        = 0;

    // Frame checker state as predicted by the testbench.
    logic [6:0]  kept_count;
    logic [7:0]  held_newest;
    logic [7:0]  held_older;
    logic [15:0] crc_acc;
    logic        dropped_any;

    mrcc_pkg::t_result expected_words[$];

    meter_response_crc_checker dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_rx_byte      (rx_byte),
        .i_frame_end    (frame_end),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_item_kind    (item_kind),
        .o_payload_byte (payload_byte),
        .o_frame_status (frame_status),
        .o_frame_length (frame_length),
        .o_last_item    (last_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reflected CRC-16 update over one byte, one bit per iteration.
    function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                      input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REV;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    task automatic clear_frame_state();
        kept_count  = '0;
        held_newest = '0;
        held_older  = '0;
        crc_acc     = CRC_SEED;
        dropped_any = 1'b0;
    endtask

    // Works out the words that one accepted byte causes and queues them.
    task automatic predict_rx_byte(input logic [7:0] b, input logic last);
        mrcc_pkg::t_result w;
        if (kept_count < FRAME_LIMIT) begin
            // The byte two places back is now known not to be CRC.
            if (kept_count >= FRAME_MIN) begin
                w              = '0;
                w.item_kind    = mrcc_pkg::KIND_PAYLOAD;
                w.payload_byte = held_older;
                w.frame_status = mrcc_pkg::ST_OK;
                expected_words.push_back(w);
                crc_acc = crc16_modbus_step(crc_acc, held_older);
            end
            held_older  = held_newest;
            held_newest = b;
            kept_count  = kept_count + 7'd1;
        end else begin
            dropped_any = 1'b1;
        end
        if (last) begin
            w              = '0;
            w.item_kind    = mrcc_pkg::KIND_STATUS;
            w.frame_length = kept_count;
            w.last_item    = 1'b1;
            if (dropped_any) begin
                w.frame_status = mrcc_pkg::ST_OVERLONG;
            end else if (kept_count < FRAME_MIN) begin
                w.frame_status = mrcc_pkg::ST_SHORT;
            end else if ({held_newest, held_older} == crc_acc) begin
                w.frame_status = mrcc_pkg::ST_OK;
            end else begin
                w.frame_status = mrcc_pkg::ST_CRC_ERR;
            end
            expected_words.push_back(w);
            clear_frame_state();
        end
    endtask

    // Offers one byte from a falling edge and returns at the falling edge after it is taken.
    task automatic send_rx_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        rx_byte   = b;
        frame_end = last;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        predict_rx_byte(b, last);
        @(negedge clk);
    endtask

    // Sends a whole frame; from three bytes up, the last two become the CRC unless told otherwise.
    task automatic send_frame(input logic [7:0] frame_bytes[$], input t_crc_fill fill);
        logic [15:0] crc;
        int          len;
        len = frame_bytes.size();
        crc = CRC_SEED;
        if (len >= FRAME_MIN && fill != CRC_AS_IS) begin
            for (int i = 1; i < len - 2; i++) begin
                crc = crc16_modbus_step(crc, frame_bytes[i]);
            end
            if (fill == CRC_FLIPPED) begin
                crc = crc ^ (16'h0001 << $urandom_range(15));
            end
            frame_bytes[len - 2] = crc[7:0];
            frame_bytes[len - 1] = crc[15:8];
        end
        for (int i = 0; i < len; i++) begin
            send_rx_byte(frame_bytes[i], i == len - 1);
        end
    endtask

    task automatic send_random_frame(input int len, input t_crc_fill fill);
        logic [7:0] frame_bytes[$];
        for (int i = 0; i < len; i++) begin
            frame_bytes.push_back(8'($urandom_range(255)));
        end
        send_frame(frame_bytes, fill);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (expected_words.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // One- and two-byte frames are too short and emit only a status.
    task automatic test_short_frames();
        logic [7:0] frame_bytes[$];
        frame_bytes.push_back(8'hFF);
        send_frame(frame_bytes, CRC_AS_IS);
        frame_bytes.delete();
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        send_frame(frame_bytes, CRC_AS_IS);
    endtask

    // Three-byte frames have an empty payload, so the CRC field must read 0xFFFF.
    task automatic test_empty_payload();
        logic [7:0] frame_bytes[$];
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'hFF);
        send_frame(frame_bytes, CRC_AS_IS);
        frame_bytes.delete();
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        send_frame(frame_bytes, CRC_FLIPPED);
    endtask

    // Short payloads at the byte extremes, one with a good CRC and one with a bad one.
    task automatic test_payload_frames();
        logic [7:0] frame_bytes[$];
        frame_bytes.push_back(8'hA5);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        send_frame(frame_bytes, CRC_GOOD);
        frame_bytes.delete();
        frame_bytes.push_back(8'h5A);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h80);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        send_frame(frame_bytes, CRC_FLIPPED);
    endtask

    // A frame of exactly the maximum size passes; one byte more is overlong.
    task automatic test_frame_size_limit();
        send_random_frame(FRAME_LIMIT, CRC_GOOD);
        send_random_frame(FRAME_LIMIT + 1, CRC_GOOD);
    endtask

    // The receiver holds off long enough for the result queue to fill and stall the input.
    task automatic test_output_backpressure();
        hold_requests++;
        send_random_frame(30, CRC_GOOD);
    endtask

    // Mostly well-formed frames of random content, with short, overlong and corrupt ones mixed in.
    task automatic test_random_frames(input int n_bytes);
        int        sent;
        int        len;
        int        roll;
        t_crc_fill fill;
        sent = 0;
        while (sent < n_bytes) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                len = $urandom_range(2, 1);
            end else if (roll < 16) begin
                len = $urandom_range(FRAME_LIMIT + 5, FRAME_LIMIT - 3);
            end else begin
                len = $urandom_range(16, 3);
            end
            roll = $urandom_range(99);
            if (roll < 75) begin
                fill = CRC_GOOD;
            end else if (roll < 90) begin
                fill = CRC_FLIPPED;
            end else begin
                fill = CRC_AS_IS;
            end
            send_random_frame(len, fill);
            sent += (len < FRAME_LIMIT) ? len : FRAME_LIMIT;
        end
    endtask

    // Receiver stall, with a long hold on request.
    always @(negedge clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else begin
            out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string field, input int exp_val, input int act_val);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, act_val);
        errors++;
    endtask

    // Compares each word taken from the block with the oldest expected one.
    always @(posedge clk) begin
        mrcc_pkg::t_result w;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got kind %0d byte %0d",
                             $time, item_kind, payload_byte);
                    errors++;
                end else begin
                    w = expected_words.pop_front();
                    if (item_kind !== w.item_kind) begin
                        report_mismatch("item_kind", w.item_kind, item_kind);
                    end
                    if (payload_byte !== w.payload_byte) begin
                        report_mismatch("payload_byte", w.payload_byte, payload_byte);
                    end
                    if (frame_status !== w.frame_status) begin
                        report_mismatch("frame_status", w.frame_status, frame_status);
                    end
                    if (frame_length !== w.frame_length) begin
                        report_mismatch("frame_length", w.frame_length, frame_length);
                    end
                    if (last_item !== w.last_item) begin
                        report_mismatch("last_item", w.last_item, last_item);
                    end
                end
            end
        end
    end

    // Ends the run if nothing moves on either channel for too long.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        frame_end = 1'b0;
        clear_frame_state();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(30, 62);
        test_short_frames();
        test_empty_payload();
        test_payload_frames();
        test_frame_size_limit();
        test_output_backpressure();
        test_random_frames(PHASE_ITEMS);

        set_idling(62, 30);
        test_random_frames(PHASE_ITEMS);

        set_idling(0, 0);
        test_random_frames(PHASE_ITEMS);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
